/* src/m3inv_pkg.sv */
// Shared constants for the 3x3 matrix inverse unit.
package m3inv_pkg;

	localparam int CELL_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int THR_WIDTH      = 32;
	localparam int NUM_CELLS      = 9;

	localparam logic [THR_WIDTH-1:0] THRESH_RESET = 32'd4295;

	// Cyclic row/column neighbors used to build the 2x2 minors.
	localparam int NEXT1 [3] = '{1, 2, 0};
	localparam int NEXT2 [3] = '{2, 0, 1};

endpackage

/* src/m3inv_div.sv */
// Pipelined restoring divider, one quotient bit per stage, nine lanes sharing one divisor.
module m3inv_div import m3inv_pkg::*; #(
	parameter int W   = CELL_WIDTH_DEF,
	parameter int DW  = 3 * CELL_WIDTH_DEF + 3,
	parameter int RW  = 4 * CELL_WIDTH_DEF + 3,
	parameter int SBW = 1
) (
	input  logic                 clk,
	input  logic [W-1:0]         en,
	input  logic [RW-1:0]        num [NUM_CELLS],
	input  logic [DW-1:0]        divisor,
	input  logic [SBW-1:0]       tag,
	output logic [W-1:0]         quot [NUM_CELLS],
	output logic [SBW-1:0]       tag_done
);

	logic [RW-1:0]  rem_s [W][NUM_CELLS];
	logic [W-1:0]   quo_s [W][NUM_CELLS];
	logic [DW-1:0]  div_s [W];
	logic [SBW-1:0] tag_s [W];

	for (genvar j = 0; j < W; j++) begin : g_step
		logic [RW-1:0]  rin [NUM_CELLS];
		logic [W-1:0]   qin [NUM_CELLS];
		logic [DW-1:0]  din;
		logic [SBW-1:0] tin;
		logic [RW:0]    trial [NUM_CELLS];

		if (j == 0) begin : g_first
			assign rin = num;
			assign din = divisor;
			assign tin = tag;
			for (genvar l = 0; l < NUM_CELLS; l++) begin : g_qz
				assign qin[l] = '0;
			end
		end else begin : g_next
			assign rin = rem_s[j-1];
			assign qin = quo_s[j-1];
			assign din = div_s[j-1];
			assign tin = tag_s[j-1];
		end

		// Trial subtraction of the divisor aligned to this stage's quotient bit.
		always_comb begin
			for (int l = 0; l < NUM_CELLS; l++) begin
				trial[l] = {1'b0, rin[l]} - ({1'b0, RW'(din)} << (W - 1 - j));
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				for (int l = 0; l < NUM_CELLS; l++) begin
					if (!trial[l][RW]) begin
						rem_s[j][l] <= trial[l][RW-1:0];
						quo_s[j][l] <= qin[l] | (W'(1) << (W - 1 - j));
					end else begin
						rem_s[j][l] <= rin[l];
						quo_s[j][l] <= qin[l];
					end
				end
				div_s[j] <= din;
				tag_s[j] <= tin;
			end
		end
	end

	assign quot     = quo_s[W-1];
	assign tag_done = tag_s[W-1];

endmodule

/* src/matrix3_inverse_unit.sv */
// Top level of the 3x3 fixed-point matrix inverse unit.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  a00 .. a22
//  result    out        out_valid / out_stall r00 .. r22, singular
//  config    in         cfg_valid / cfg_ready cfg_data (singular_threshold)
//
// One matrix may be transferred in every cycle while in_stall is low. The pipeline
// holds eight stages of capture, multiply, adjugate, determinant and threshold
// test, one stage per quotient bit in the divider, and the output stage.
// Reset clears all stage valid bits and loads the threshold with its reset value.
// A stalled result holds in the output stage; earlier stages keep moving while
// any later stage is empty, so input is refused only when every stage is full.
module matrix3_inverse_unit import m3inv_pkg::*; #(
	parameter int CELL_WIDTH = CELL_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [CELL_WIDTH-1:0] a00,
	input  logic signed [CELL_WIDTH-1:0] a01,
	input  logic signed [CELL_WIDTH-1:0] a02,
	input  logic signed [CELL_WIDTH-1:0] a10,
	input  logic signed [CELL_WIDTH-1:0] a11,
	input  logic signed [CELL_WIDTH-1:0] a12,
	input  logic signed [CELL_WIDTH-1:0] a20,
	input  logic signed [CELL_WIDTH-1:0] a21,
	input  logic signed [CELL_WIDTH-1:0] a22,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [CELL_WIDTH-1:0] r00,
	output logic signed [CELL_WIDTH-1:0] r01,
	output logic signed [CELL_WIDTH-1:0] r02,
	output logic signed [CELL_WIDTH-1:0] r10,
	output logic signed [CELL_WIDTH-1:0] r11,
	output logic signed [CELL_WIDTH-1:0] r12,
	output logic signed [CELL_WIDTH-1:0] r20,
	output logic signed [CELL_WIDTH-1:0] r21,
	output logic signed [CELL_WIDTH-1:0] r22,
	output logic                         singular,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [THR_WIDTH-1:0]         cfg_data
);

	localparam int W    = CELL_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int PW   = 2 * W;           // cell times cell
	localparam int CW   = 2 * W + 1;       // adjugate cell
	localparam int MW   = 2 * W + 1;       // cell times half an adjugate cell
	localparam int DW   = 3 * W + 3;       // determinant
	localparam int RW   = DW + W;          // divider remainder
	localparam int CMPW = DW + THR_WIDTH + 3 * F;
	localparam int SBW  = NUM_CELLS * W + 2 * NUM_CELLS + 1;
	localparam int NS   = W + 9;           // total register stages
	localparam int DIV0 = 9;               // first divider stage index

	// Stage valid bits and the bubble-collapsing advance enables.
	logic [NS:1] v_q;
	logic [NS:1] en;

	assign en[NS] = !v_q[NS] || !out_stall;
	for (genvar k = 1; k < NS; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = v_q[NS];

	// The threshold register is only written while the pipeline is empty.
	logic [THR_WIDTH-1:0] thr_q;

	assign cfg_ready = ~|v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Stage 1: capture the matrix, row by row.
	logic signed [W-1:0] cell_s1 [NUM_CELLS];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cell_s1 <= '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
		end
	end

	// Stage 2: the two products of each 2x2 minor. Lane i*3+j holds the
	// adjugate cell at row i, column j, so the transpose is built in here.
	logic signed [PW-1:0] p1_s2 [NUM_CELLS];
	logic signed [PW-1:0] p2_s2 [NUM_CELLS];
	logic signed [W-1:0]  cell_s2 [NUM_CELLS];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p1_s2[i*3+j] <= cell_s1[NEXT1[j]*3 + NEXT1[i]]
					              * cell_s1[NEXT2[j]*3 + NEXT2[i]];
					p2_s2[i*3+j] <= cell_s1[NEXT1[j]*3 + NEXT2[i]]
					              * cell_s1[NEXT2[j]*3 + NEXT1[i]];
				end
			end
			cell_s2 <= cell_s1;
		end
	end

	// Stage 3: adjugate cells, exact.
	logic signed [CW-1:0] adj_s3 [NUM_CELLS];
	logic signed [W-1:0]  cell_s3 [NUM_CELLS];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int l = 0; l < NUM_CELLS; l++) begin
				adj_s3[l] <= CW'(p1_s2[l]) - CW'(p2_s2[l]);
			end
			cell_s3 <= cell_s2;
		end
	end

	// Stage 4: first-row cells times the first adjugate column, each product
	// split into an upper signed half and a lower unsigned half.
	logic signed [MW-1:0] mh_s4 [3];
	logic signed [MW-1:0] ml_s4 [3];
	logic signed [CW-1:0] adj_s4 [NUM_CELLS];
	logic signed [W-1:0]  cell_s4 [NUM_CELLS];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int k = 0; k < 3; k++) begin
				mh_s4[k] <= cell_s3[k] * $signed(adj_s3[k*3][CW-1:W]);
				ml_s4[k] <= cell_s3[k] * $signed({1'b0, adj_s3[k*3][W-1:0]});
			end
			adj_s4  <= adj_s3;
			cell_s4 <= cell_s3;
		end
	end

	// Stage 5: recombine the halves of each determinant term.
	logic signed [DW-1:0] dk_s5 [3];
	logic signed [CW-1:0] adj_s5 [NUM_CELLS];
	logic signed [W-1:0]  cell_s5 [NUM_CELLS];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int k = 0; k < 3; k++) begin
				dk_s5[k] <= (DW'(mh_s4[k]) <<< W) + DW'(ml_s4[k]);
			end
			adj_s5  <= adj_s4;
			cell_s5 <= cell_s4;
		end
	end

	// Stage 6: the determinant.
	logic signed [DW-1:0] det_s6;
	logic signed [CW-1:0] adj_s6 [NUM_CELLS];
	logic signed [W-1:0]  cell_s6 [NUM_CELLS];

	always_ff @(posedge clk) begin
		if (en[6]) begin
			det_s6  <= dk_s5[0] + dk_s5[1] + dk_s5[2];
			adj_s6  <= adj_s5;
			cell_s6 <= cell_s5;
		end
	end

	// Stage 7: magnitudes and signs; each numerator is scaled by 2^(2F).
	logic [CW-1:0]        aabs [NUM_CELLS];
	logic [DW-1:0]        adet_s7;
	logic                 detneg_s7;
	logic                 dzero_s7;
	logic [RW-1:0]        num_s7 [NUM_CELLS];
	logic [8:0]           cneg_s7;
	logic signed [W-1:0]  cell_s7 [NUM_CELLS];

	always_comb begin
		for (int l = 0; l < NUM_CELLS; l++) begin
			aabs[l] = adj_s6[l][CW-1] ? CW'(-adj_s6[l]) : CW'(adj_s6[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			detneg_s7 <= det_s6[DW-1];
			adet_s7   <= det_s6[DW-1] ? DW'(-det_s6) : DW'(det_s6);
			dzero_s7  <= (det_s6 == '0);
			for (int l = 0; l < NUM_CELLS; l++) begin
				num_s7[l]  <= RW'(aabs[l]) << (2 * F);
				cneg_s7[l] <= adj_s6[l][CW-1];
			end
			cell_s7 <= cell_s6;
		end
	end

	// Stage 8: singular test against the threshold, and quotient overflow
	// detection (a quotient of 2^W or more always saturates).
	logic [CMPW-1:0]        det_scaled;
	logic [CMPW-1:0]        thr_scaled;
	logic [RW-1:0]          num_s8 [NUM_CELLS];
	logic [DW-1:0]          adet_s8;
	logic [8:0]             negq_s8;
	logic [8:0]             ovf_s8;
	logic                   sing_s8;
	logic [8:0][W-1:0]      cellp_s8;

	assign det_scaled = CMPW'(adet_s7) << THR_WIDTH;
	assign thr_scaled = CMPW'(thr_q) << (3 * F);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			sing_s8 <= dzero_s7 || (det_scaled < thr_scaled);
			for (int l = 0; l < NUM_CELLS; l++) begin
				ovf_s8[l]   <= num_s7[l] >= (RW'(adet_s7) << W);
				negq_s8[l]  <= cneg_s7[l] ^ detneg_s7;
				cellp_s8[l] <= cell_s7[l];
			end
			num_s8  <= num_s7;
			adet_s8 <= adet_s7;
		end
	end

	// Divider: stages DIV0 .. DIV0+W-1, the rest of the item rides along as a tag.
	logic [W-1:0]   quot [NUM_CELLS];
	logic [SBW-1:0] tag_done;

	m3inv_div #(
		.W   (W),
		.DW  (DW),
		.RW  (RW),
		.SBW (SBW)
	) u_div (
		.clk      (clk),
		.en       (en[DIV0 +: W]),
		.num      (num_s8),
		.divisor  (adet_s8),
		.tag      ({sing_s8, ovf_s8, negq_s8, cellp_s8}),
		.quot     (quot),
		.tag_done (tag_done)
	);

	// Output stage: saturate, apply sign, or pass the input through when singular.
	logic              sing_d;
	logic [8:0]        ovf_d;
	logic [8:0]        negq_d;
	logic [8:0][W-1:0] cell_d;
	logic [W-1:0]      lim [NUM_CELLS];
	logic [W-1:0]      qsat [NUM_CELLS];
	logic [W-1:0]      res_next [NUM_CELLS];
	logic [W-1:0]      res_s9 [NUM_CELLS];
	logic              sing_s9;

	assign {sing_d, ovf_d, negq_d, cell_d} = tag_done;

	always_comb begin
		for (int l = 0; l < NUM_CELLS; l++) begin
			lim[l]  = negq_d[l] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
			qsat[l] = (ovf_d[l] || (quot[l] > lim[l])) ? lim[l] : quot[l];
			if (sing_d) begin
				res_next[l] = cell_d[l];
			end else if (negq_d[l]) begin
				res_next[l] = W'(-qsat[l]);
			end else begin
				res_next[l] = qsat[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			res_s9  <= res_next;
			sing_s9 <= sing_d;
		end
	end

	assign r00      = res_s9[0];
	assign r01      = res_s9[1];
	assign r02      = res_s9[2];
	assign r10      = res_s9[3];
	assign r11      = res_s9[4];
	assign r12      = res_s9[5];
	assign r20      = res_s9[6];
	assign r21      = res_s9[7];
	assign r22      = res_s9[8];
	assign singular = sing_s9;

endmodule

/* src/m3inv_checker.sv */
// Port-level checks for the matrix inverse unit, attached by bind.
module m3inv_checker import m3inv_pkg::*; #(
	parameter int CELL_WIDTH = CELL_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [CELL_WIDTH-1:0] r00,
	input logic [CELL_WIDTH-1:0] r01,
	input logic [CELL_WIDTH-1:0] r02,
	input logic [CELL_WIDTH-1:0] r10,
	input logic [CELL_WIDTH-1:0] r11,
	input logic [CELL_WIDTH-1:0] r12,
	input logic [CELL_WIDTH-1:0] r20,
	input logic [CELL_WIDTH-1:0] r21,
	input logic [CELL_WIDTH-1:0] r22,
	input logic                  singular
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(r00) && $stable(r01) && $stable(r02)
			&& $stable(r10) && $stable(r11) && $stable(r12) && $stable(r20)
			&& $stable(r21) && $stable(r22) && $stable(singular))
		else $error("result changed while stalled");

	// Input is refused only when the output itself is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// Nothing comes out in the first cycle after reset.
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result offered right after reset");

endmodule

bind matrix3_inverse_unit m3inv_checker #(.CELL_WIDTH(CELL_WIDTH)) u_m3inv_checker (.*);

/* bench/tb.sv */
// Self-checking testbench for the 3x3 fixed-point matrix inverse unit.
`timescale 1ns / 1ps

module tb;
	import m3inv_pkg::*;

	localparam int CW = CELL_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	// Settle for longer than the block's pipeline is deep.
	localparam int SETTLE = CW + 20;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef logic [NUM_CELLS-1:0][CW-1:0] mat_t;

	typedef struct packed {
		mat_t r;
		logic sing;
	} inverse_t;

	typedef struct packed {
		mat_t a;
		logic typed;
		mat_t r;
		logic sing;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_stall;
	mat_t cells = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	mat_t res;
	logic singular;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [THR_WIDTH-1:0] cfg_data = '0;

	logic [THR_WIDTH-1:0] thr_shadow = THRESH_RESET;
	inverse_t pending_inverses[$];
	vector_t directed[$];
	int failures = 0;
	int matrices_sent = 0;
	int inverses_checked = 0;
	int singular_seen = 0;
	int thresholds_used = 1;
	int idle_cycles = 0;
	int cyc = 0;
	int burst_left = 0;

	// Reset is long gone before the first edge at which stall matters.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	matrix3_inverse_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a00(cells[0]), .a01(cells[1]), .a02(cells[2]),
		.a10(cells[3]), .a11(cells[4]), .a12(cells[5]),
		.a20(cells[6]), .a21(cells[7]), .a22(cells[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.r00(res[0]), .r01(res[1]), .r02(res[2]),
		.r10(res[3]), .r11(res[4]), .r12(res[5]),
		.r20(res[6]), .r21(res[7]), .r22(res[8]),
		.singular(singular),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Exact inverse: adjugate over determinant with 128-bit integers, which hold
	// every intermediate value at this cell width without loss.
	function automatic inverse_t invert(mat_t a, logic [THR_WIDTH-1:0] thr);
		logic signed [127:0] m [3][3];
		logic signed [127:0] adj [3][3];
		logic signed [127:0] det;
		logic [127:0] adet, num, q, lim;
		logic negq;
		inverse_t o;
		int i, j;
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++)
				m[i][j] = $signed(a[i*3+j]);
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++)
				adj[i][j] = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
					- m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
		det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
		adet = (det < 0) ? -det : det;
		// |D| * 2^32 < thr * 2^(3*FB) reduces to |D| < thr * 2^(3*FB-32).
		if (det == 0 || adet < ({96'b0, thr} << (3*FB - 32))) begin
			o.r = a;
			o.sing = 1'b1;
			return o;
		end
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				negq = (adj[i][j] < 0) != (det < 0);
				num = ((adj[i][j] < 0) ? -adj[i][j] : adj[i][j]);
				num = num << (2*FB);
				q = num / adet;
				lim = negq ? (128'd1 << (CW-1)) : ((128'd1 << (CW-1)) - 1);
				if (q > lim)
					q = lim;
				o.r[i*3+j] = negq ? -q[CW-1:0] : q[CW-1:0];
			end
		end
		o.sing = 1'b0;
		return o;
	endfunction

	function automatic mat_t diag(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		mat_t m;
		m = '0;
		m[0] = x;
		m[4] = y;
		m[8] = z;
		return m;
	endfunction

	function automatic vector_t row(mat_t a, logic typed, mat_t r, logic sing);
		vector_t v;
		v.a = a;
		v.typed = typed;
		v.r = r;
		v.sing = sing;
		return v;
	endfunction

	// Random matrix with a mix of shapes: full-range noise, moderate Q16.16
	// values, tiny cells that drive the quotient into saturation, and matrices
	// with two equal rows so the determinant is exactly zero.
	function automatic mat_t random_matrix();
		mat_t m;
		int k, shape;
		shape = $urandom_range(0, 9);
		for (k = 0; k < NUM_CELLS; k++) begin
			case (shape)
				0, 1, 2: m[k] = $urandom;
				3, 4, 5: m[k] = $urandom_range(0, 1 << 19) - (1 << 18);
				6, 7:    m[k] = $urandom_range(0, 8) - 4;
				default: m[k] = $urandom_range(0, 1 << 17) - (1 << 16);
			endcase
		end
		if (shape == 9) begin
			m[6] = m[0];
			m[7] = m[1];
			m[8] = m[2];
		end
		return m;
	endfunction

	// One transfer on the input channel, with bursts of random length split by
	// random gaps. Valid is held with a steady payload until the transfer.
	task automatic send(mat_t a, logic typed, inverse_t typed_result);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cells <= a;
		do @(posedge clk); while (in_stall);
		pending_inverses.push_back(typed ? typed_result : invert(a, thr_shadow));
		matrices_sent++;
		burst_left--;
	endtask

	// Stop sending and wait until every inverse has come back and the pipeline
	// has had time to empty.
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		burst_left = 0;
		while (pending_inverses.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_threshold(logic [THR_WIDTH-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		thr_shadow = v;
		thresholds_used++;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int n);
		repeat (n) send(random_matrix(), 1'b0, '0);
	endtask

	task automatic run_directed(int first, int last);
		inverse_t t;
		for (int i = first; i <= last; i++) begin
			t.r = directed[i].r;
			t.sing = directed[i].sing;
			send(directed[i].a, directed[i].typed, t);
		end
	endtask

	// The receiver cycles through four stall patterns: none, light random,
	// heavy random and a fixed period.
	always @(negedge clk) begin
		cyc <= cyc + 1;
		case ((cyc / 256) % 4)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= cyc[2];
		endcase
	end

	// Result checker: every transfer on the result channel is compared with
	// the oldest pending inverse.
	always @(posedge clk) begin
		inverse_t want;
		if (out_valid && !out_stall) begin
			if (pending_inverses.size() == 0) begin
				$display("%0t: result with no matrix outstanding", $time);
				failures++;
			end else begin
				want = pending_inverses.pop_front();
				for (int k = 0; k < NUM_CELLS; k++) begin
					if (res[k] !== want.r[k]) begin
						$display("%0t: r%0d%0d expected %h got %h",
							$time, k / 3, k % 3, want.r[k], res[k]);
						failures++;
					end
				end
				if (singular !== want.sing) begin
					$display("%0t: singular expected %b got %b", $time, want.sing, singular);
					failures++;
				end
				inverses_checked++;
				if (want.sing)
					singular_seen++;
			end
		end
	end

	// Watchdog on cycles in which nothing at all is transferred.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("*** FAILED ***");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		mat_t one;
		// The falling reset edge lands after every process is waiting on it.
		arst_n <= 1'b0;
		one = diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

		// Rows 0..13 run at the reset threshold.
		directed.push_back(row(one, 1, one, 0));
		directed.push_back(row('0, 1, '0, 1));
		directed.push_back(row({NUM_CELLS{32'h8000_0000}}, 1, {NUM_CELLS{32'h8000_0000}}, 1));
		directed.push_back(row({NUM_CELLS{32'h7FFF_FFFF}}, 1, {NUM_CELLS{32'h7FFF_FFFF}}, 1));
		directed.push_back(row(diag(32'h1000, 32'h1000, 32'h1000), 1,
			diag(32'h10_0000, 32'h10_0000, 32'h10_0000), 0));
		directed.push_back(row(diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000), 1,
			diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000), 0));
		directed.push_back(row(diag(1, 1, 1), 1, diag(1, 1, 1), 1));
		directed.push_back(row(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, '0, 0));
		directed.push_back(row(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, '0, 0));
		directed.push_back(row({32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF,
			32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0003_0000}, 0, '0, 0));
		directed.push_back(row({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0,
			32'h0001_0000, 32'h0, 32'h0}, 0, '0, 0));
		directed.push_back(row(diag(32'h10, 32'h0001_0000, 32'h7FFF_FFFF), 0, '0, 0));
		directed.push_back(row(diag(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000), 0, '0, 0));
		directed.push_back(row({32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
			32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h000A_0000},
			0, '0, 0));
		// Rows 14..17 run with the threshold at zero: saturation at both ends,
		// and a zero determinant still taking the pass-through path.
		directed.push_back(row(diag(1, 1, 1), 1,
			diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0));
		directed.push_back(row(diag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
			diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0));
		directed.push_back(row('0, 1, '0, 1));
		directed.push_back(row(diag(1, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 0, '0, 0));

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		run_directed(0, 13);
		run_random(200);

		set_threshold('0);
		run_directed(14, 17);
		run_random(200);

		set_threshold('1);
		run_random(120);

		set_threshold(32'h0001_0000);
		run_random(150);

		set_threshold($urandom);
		run_random(150);

		drain();
		$display("Sent %0d matrices under %0d threshold settings; %0d inverses checked,",
			matrices_sent, thresholds_used, inverses_checked);
		$display("%0d of them flagged singular and passed through.", singular_seen);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
src/m3inv_pkg.sv
src/m3inv_div.sv
src/matrix3_inverse_unit.sv
src/m3inv_checker.sv
bench/tb.sv
